// ----- hdl/sfr_pkg.sv -----
// Shared types, codes and constants of the serial frame receiver.
`timescale 1ns / 1ps

package sfr_pkg;

   localparam int NUM_SLOTS_DEFAULT = 4;
   localparam int SLOT_REGS         = 4;
   localparam int CSR_INDEX_W       = 3;
   localparam int CSR_DATA_W        = 8;

   localparam logic [7:0] SOH_CODE = 8'h01;
   localparam logic [7:0] STX_CODE = 8'h02;
   localparam logic [7:0] ETX_CODE = 8'h03;
   localparam logic [7:0] EOT_CODE = 8'h04;

   localparam logic [CSR_INDEX_W-1:0] REG_STATION = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SLOT0   = 3'd1;

   localparam int HEADER_LEN = 6;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_PAYLOAD = 3'd1,
      PH_ETX     = 3'd2,
      PH_SUM     = 3'd3,
      PH_EOT     = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_ACCEPT  = 2'd1,
      KIND_DROP    = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      DROP_ETX = 2'd0,
      DROP_SUM = 2'd1,
      DROP_EOT = 2'd2
   } drop_type;

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data_byte;
      logic [7:0] byte_index;
      logic [7:0] sender;
      logic [7:0] command;
      logic [7:0] length;
      logic       command_known;
      drop_type   drop_reason;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type payload;
   } result_type;

endpackage

// ----- hdl/sfr_channel_if.sv -----
// Valid/ready channel interfaces for received bytes and frame results.
`timescale 1ns / 1ps

interface sfr_req_if;
   import sfr_pkg::*;

   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface sfr_rsp_if;
   import sfr_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/sfr_csr_regs.sv -----
// Station address and command slot registers.
`timescale 1ns / 1ps

module sfr_csr_regs #(
   parameter int NUM_SLOTS = sfr_pkg::NUM_SLOTS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [sfr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]     csr_write_data,
   output logic [7:0]                         station_address,
   output logic [NUM_SLOTS-1:0][7:0]          command_slots
);
   import sfr_pkg::*;

   logic [7:0]                station_ff;
   logic [NUM_SLOTS-1:0][7:0] slots_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         station_ff <= '0;
         slots_ff   <= '0;
      end else if (csr_write_en) begin
         if (csr_index == REG_STATION) begin
            station_ff <= csr_write_data[7:0];
         end
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (csr_index == REG_SLOT0 + CSR_INDEX_W'(i)) begin
               slots_ff[i] <= csr_write_data[7:0];
            end
         end
      end
   end

   assign station_address = station_ff;
   assign command_slots   = slots_ff;

endmodule

// ----- hdl/sfr_req_stage.sv -----
// Input register for received bytes.
`timescale 1ns / 1ps

module sfr_req_stage (
   input  logic           clock,
   input  logic           reset,
   sfr_req_if.sink        req_chan,
   input  logic           advance,
   output logic           byte_valid,
   output logic [7:0]     rx_byte
);
   import sfr_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       take;

   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_chan.payload.rx_byte;
      end
   end

   assign byte_valid = valid_ff;
   assign rx_byte    = byte_ff;

endmodule

// ----- hdl/sfr_frame_core.sv -----
// Frame state machine: header hunt, payload pass-through, trailer checks.
`timescale 1ns / 1ps

module sfr_frame_core #(
   parameter int NUM_SLOTS = sfr_pkg::NUM_SLOTS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic [7:0]                rx_byte,
   input  logic [7:0]                station_address,
   input  logic [NUM_SLOTS-1:0][7:0] command_slots,
   output sfr_pkg::result_type       result
);
   import sfr_pkg::*;

   phase_type  phase_ff,    phase_in;
   logic [7:0] window_ff    [HEADER_LEN];
   logic [7:0] window_in    [HEADER_LEN];
   logic [7:0] shifted      [HEADER_LEN];
   logic [7:0] length_ff,   length_in;
   logic [7:0] position_ff, position_in;
   logic [7:0] sender_ff,   sender_in;
   logic [7:0] command_ff,  command_in;
   logic [7:0] sum_ff,      sum_in;
   logic       known;
   logic       end_frame;

   always_comb begin
      for (int i = 0; i < HEADER_LEN - 1; i++) begin
         shifted[i] = window_ff[i+1];
      end
      shifted[HEADER_LEN-1] = rx_byte;
   end

   always_comb begin
      known = 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (command_slots[i] != 8'h00 && command_slots[i] == command_ff) begin
            known = 1'b1;
         end
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      window_in   = window_ff;
      length_in   = length_ff;
      position_in = position_ff;
      sender_in   = sender_ff;
      command_in  = command_ff;
      sum_in      = sum_ff;
      end_frame   = 1'b0;
      result      = '0;
      if (advance) begin
         case (phase_ff)
            PH_PAYLOAD: begin
               result.valid              = 1'b1;
               result.payload.kind       = KIND_PAYLOAD;
               result.payload.data_byte  = rx_byte;
               result.payload.byte_index = position_ff;
               sum_in                    = sum_ff + rx_byte;
               position_in               = position_ff + 8'd1;
               if (position_in == length_ff) begin
                  phase_in = PH_ETX;
               end
            end
            PH_ETX: begin
               if (rx_byte != ETX_CODE) begin
                  result.valid               = 1'b1;
                  result.payload.kind        = KIND_DROP;
                  result.payload.drop_reason = DROP_ETX;
                  end_frame                  = 1'b1;
               end else begin
                  phase_in = PH_SUM;
               end
            end
            PH_SUM: begin
               if (rx_byte != sum_ff) begin
                  result.valid               = 1'b1;
                  result.payload.kind        = KIND_DROP;
                  result.payload.drop_reason = DROP_SUM;
                  end_frame                  = 1'b1;
               end else begin
                  phase_in = PH_EOT;
               end
            end
            PH_EOT: begin
               result.valid = 1'b1;
               end_frame    = 1'b1;
               if (rx_byte != EOT_CODE) begin
                  result.payload.kind        = KIND_DROP;
                  result.payload.drop_reason = DROP_EOT;
               end else begin
                  result.payload.kind          = KIND_ACCEPT;
                  result.payload.sender        = sender_ff;
                  result.payload.command       = command_ff;
                  result.payload.length        = length_ff;
                  result.payload.command_known = known;
               end
            end
            default: begin
               window_in = shifted;
               if (shifted[0] == SOH_CODE && shifted[5] == STX_CODE &&
                   shifted[1] == station_address) begin
                  sender_in   = shifted[2];
                  command_in  = shifted[3];
                  length_in   = shifted[4];
                  position_in = '0;
                  sum_in      = shifted[1] + shifted[2] + shifted[3] + shifted[4];
                  phase_in    = (shifted[4] == 8'h00) ? PH_ETX : PH_PAYLOAD;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
         endcase
         if (end_frame) begin
            phase_in    = PH_HUNT;
            length_in   = '0;
            position_in = '0;
            sender_in   = '0;
            command_in  = '0;
            sum_in      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         length_ff   <= '0;
         position_ff <= '0;
         sender_ff   <= '0;
         command_ff  <= '0;
         sum_ff      <= '0;
         for (int i = 0; i < HEADER_LEN; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         phase_ff    <= phase_in;
         length_ff   <= length_in;
         position_ff <= position_in;
         sender_ff   <= sender_in;
         command_ff  <= command_in;
         sum_ff      <= sum_in;
         window_ff   <= window_in;
      end
   end

   a_payload_length_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> length_ff != 8'h00)
      else $error("payload phase with zero frame length");

   a_payload_position_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> position_ff < length_ff)
      else $error("payload position reached frame length");

   a_frame_end_hunts: assert property (@(posedge clock) disable iff (reset)
      result.valid && result.payload.kind != KIND_PAYLOAD
      |=> phase_ff == PH_HUNT && sum_ff == 8'h00 && length_ff == 8'h00)
      else $error("frame state not cleared after frame end");

endmodule

// ----- hdl/sfr_rsp_stage.sv -----
// Result register feeding the response channel.
`timescale 1ns / 1ps

module sfr_rsp_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                byte_valid,
   input  sfr_pkg::result_type result,
   output logic                advance,
   sfr_rsp_if.source           rsp_chan
);
   import sfr_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type payload_ff;

   assign advance = byte_valid && (!valid_ff || rsp_chan.ready);

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = result.valid;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         payload_ff <= result.payload;
      end
   end

   assign rsp_chan.valid   = valid_ff;
   assign rsp_chan.payload = payload_ff;

endmodule

// ----- hdl/serial_frame_receiver.sv -----
// Top level of the serial frame receiver.
// The block takes one received byte per clock and keeps that rate while
// results flow out without stalls. Each byte passes an input register, one
// pass of frame logic (a compare, an 8-bit add and a phase update) and a
// result register, from which its result is offered on the response channel.
// Payload bytes come out as they arrive; a frame ends with one accept or drop
// result after its EOT, ETX or sum byte. Header bytes produce no result.
// Write the station address and command slots only while no bytes are in
// flight; registers take effect on the next byte processed.
`timescale 1ns / 1ps

module serial_frame_receiver #(
   parameter int NUM_SLOTS = sfr_pkg::NUM_SLOTS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   sfr_req_if.sink                         req_chan,
   sfr_rsp_if.source                       rsp_chan,
   input  logic                            csr_write_en,
   input  logic [sfr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import sfr_pkg::*;

   logic                      advance;
   logic                      byte_valid;
   logic [7:0]                rx_byte;
   logic [7:0]                station_address;
   logic [NUM_SLOTS-1:0][7:0] command_slots;
   result_type                result;

   sfr_csr_regs #(.NUM_SLOTS(NUM_SLOTS)) u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .station_address (station_address),
      .command_slots   (command_slots)
   );

   sfr_req_stage u_req (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (advance),
      .byte_valid (byte_valid),
      .rx_byte    (rx_byte)
   );

   sfr_frame_core #(.NUM_SLOTS(NUM_SLOTS)) u_core (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .rx_byte         (rx_byte),
      .station_address (station_address),
      .command_slots   (command_slots),
      .result          (result)
   );

   sfr_rsp_stage u_rsp (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .result     (result),
      .advance    (advance),
      .rsp_chan   (rsp_chan)
   );

endmodule
